/* src/ptgc_pkg.sv */
// Shared types and codes for the press-and-tap gesture classifier.
// Holds the poll and gesture payload structs, configuration and code constants.
// No dependencies.
package ptgc_pkg;

  localparam int TIME_BITS_DEFAULT = 32;

  // Page turn modes.
  localparam logic [1:0] MODE_BUTTONS = 2'd0;
  localparam logic [1:0] MODE_TAP     = 2'd1;
  localparam logic [1:0] MODE_SWIPE   = 2'd2;

  // Gesture kinds.
  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_NEXT     = 3'd1;
  localparam logic [2:0] KIND_PREV     = 3'd2;
  localparam logic [2:0] KIND_CONTENTS = 3'd3;
  localparam logic [2:0] KIND_ACTION   = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_PAGE_TURN_MODE       = 3'd0;
  localparam logic [2:0] REG_DOUBLE_TAP_ACTION    = 3'd1;
  localparam logic [2:0] REG_UP_SHORT_ACTION      = 3'd2;
  localparam logic [2:0] REG_UP_LONG_ACTION       = 3'd3;
  localparam logic [2:0] REG_DOWN_SHORT_ACTION    = 3'd4;
  localparam logic [2:0] REG_DOWN_LONG_ACTION     = 3'd5;
  localparam logic [2:0] REG_LONG_PRESS_MS        = 3'd6;
  localparam logic [2:0] REG_DOUBLE_TAP_WINDOW_MS = 3'd7;

  localparam logic [15:0] LONG_PRESS_MS_RESET        = 16'd500;
  localparam logic [15:0] DOUBLE_TAP_WINDOW_MS_RESET = 16'd300;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        tap_event;
    logic        tap_right;
    logic        up_pressed;
    logic        down_pressed;
  } poll_t;

  typedef struct packed {
    logic       handled;
    logic [2:0] gesture_kind;
    logic [7:0] action_code;
  } gesture_t;

  // Per-button settings handed to a button tracker.
  typedef struct packed {
    logic [15:0] long_ms;
    logic [7:0]  short_code;
    logic [7:0]  long_code;
  } btn_cfg_t;

endpackage

/* src/ptgc_button.sv */
// Press tracker for one button: active mark, press start time, long-fired mark.
// Decides short and long presses for the current poll. Uses ptgc_pkg.
module ptgc_button import ptgc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 pressed,
  input  logic [TIME_BITS-1:0] now,
  input  btn_cfg_t             cfg,
  output logic                 fire,
  output logic [7:0]           code
);

  localparam int CW = TIME_BITS + 16;

  logic                 active;
  logic                 long_done;
  logic [TIME_BITS-1:0] start_time;

  logic [TIME_BITS-1:0] held;
  logic                 press_edge;
  logic                 long_fire;
  logic                 release_now;

  always_comb begin
    held        = now - start_time;
    press_edge  = pressed && !active;
    long_fire   = pressed && active && !long_done &&
                  (CW'(held) >= CW'(cfg.long_ms));
    release_now = !pressed && active;
    fire        = long_fire || (release_now && !long_done);
    code        = long_fire ? cfg.long_code : cfg.short_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      long_done <= 1'b0;
    end else if (step) begin
      if (press_edge) begin
        active    <= 1'b1;
        long_done <= 1'b0;
      end else if (long_fire) begin
        long_done <= 1'b1;
      end else if (release_now) begin
        active <= 1'b0;
      end
    end
  end

  // The start time only matters while the button is active.
  always_ff @(posedge clk) begin
    if (step && press_edge) begin
      start_time <= now;
    end
  end

endmodule

/* src/press_and_tap_gesture_classifier.sv */
// Top level of the press-and-tap gesture classifier.
// Uses ptgc_pkg and two ptgc_button trackers.
//
// The poll channel (poll_valid, poll_ready, poll) carries one sample per
// transfer: a millisecond timestamp, a qualified tap with its side, and the
// levels of the up and down buttons. Every poll produces exactly one gesture
// transfer on the gesture channel (gesture_valid, gesture_ready, gesture),
// which reports whether the poll consumed an event and which gesture it was:
// an expired single tap turning a page, a double tap, a contents tap, a tap
// page turn, or a short or long button press.
//
// A poll is captured in an input register; when it advances, the gesture
// logic runs, the tap and button state updates, and the result lands in
// the output register, which raises gesture_valid. One poll is taken every
// cycle while the receiver keeps up. When the receiver stalls, the result
// waits in the output register, one more poll waits in the input register,
// and poll_ready drops after that.
//
// Configuration is written through cfg_write, cfg_index and cfg_data, one
// register per cycle. The user must write it only while no poll is in
// flight; the block does not enforce this. Synchronous reset clears both
// pipeline registers, the pending tap, the button marks and the
// configuration (hold time 500 ms, double-tap window 300 ms, rest zero).
module press_and_tap_gesture_classifier import ptgc_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        poll_valid,
  output logic        poll_ready,
  input  poll_t       poll,
  output logic        gesture_valid,
  input  logic        gesture_ready,
  output gesture_t    gesture,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = TIME_BITS + 16;

  // Configuration registers.
  logic [1:0]  page_turn_mode;
  logic [7:0]  double_tap_action;
  logic [7:0]  up_short_action;
  logic [7:0]  up_long_action;
  logic [7:0]  down_short_action;
  logic [7:0]  down_long_action;
  logic [15:0] long_press_ms;
  logic [15:0] double_tap_window_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_turn_mode       <= MODE_BUTTONS;
      double_tap_action    <= '0;
      up_short_action      <= '0;
      up_long_action       <= '0;
      down_short_action    <= '0;
      down_long_action     <= '0;
      long_press_ms        <= LONG_PRESS_MS_RESET;
      double_tap_window_ms <= DOUBLE_TAP_WINDOW_MS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PAGE_TURN_MODE:       page_turn_mode       <= cfg_data[1:0];
        REG_DOUBLE_TAP_ACTION:    double_tap_action    <= cfg_data[7:0];
        REG_UP_SHORT_ACTION:      up_short_action      <= cfg_data[7:0];
        REG_UP_LONG_ACTION:       up_long_action       <= cfg_data[7:0];
        REG_DOWN_SHORT_ACTION:    down_short_action    <= cfg_data[7:0];
        REG_DOWN_LONG_ACTION:     down_long_action     <= cfg_data[7:0];
        REG_LONG_PRESS_MS:        long_press_ms        <= cfg_data;
        REG_DOUBLE_TAP_WINDOW_MS: double_tap_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register and the advance condition of the two-stage pipeline.
  poll_t poll_q;
  logic  poll_q_valid;
  logic  advance;

  assign advance    = poll_q_valid && (!gesture_valid || gesture_ready);
  assign poll_ready = !poll_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_q_valid <= 1'b0;
    end else if (poll_ready) begin
      poll_q_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_valid && poll_ready) begin
      poll_q <= poll;
    end
  end

  // Timestamp at the internal time width: truncated or zero-extended.
  logic [TIME_BITS+31:0] now_wide;
  logic [TIME_BITS-1:0]  now;

  assign now_wide = {{TIME_BITS{1'b0}}, poll_q.now_ms};
  assign now      = now_wide[TIME_BITS-1:0];

  // Pending first tap.
  logic                 tap_pending;
  logic                 pending_forward;
  logic [TIME_BITS-1:0] pending_time;

  logic                 tap_pending_next;
  logic [TIME_BITS-1:0] tap_gap;
  logic                 expired;
  logic                 tap_handled;
  logic                 store_tap;
  logic [2:0]           tap_kind;
  logic [7:0]           tap_code;

  always_comb begin
    tap_gap          = now - pending_time;
    expired          = tap_pending && (CW'(tap_gap) > CW'(double_tap_window_ms));
    tap_pending_next = tap_pending && !expired;
    tap_handled      = 1'b0;
    store_tap        = 1'b0;
    tap_kind         = KIND_NONE;
    tap_code         = '0;
    if (expired && page_turn_mode == MODE_TAP) begin
      // An expired single tap turns the page toward its side.
      tap_handled = 1'b1;
      tap_kind    = pending_forward ? KIND_NEXT : KIND_PREV;
    end else if (poll_q.tap_event) begin
      if (double_tap_action != '0) begin
        tap_handled = 1'b1;
        if (tap_pending_next) begin
          // Second tap inside the window: not expired means within it.
          tap_pending_next = 1'b0;
          tap_kind         = KIND_ACTION;
          tap_code         = double_tap_action;
        end else begin
          tap_pending_next = 1'b1;
          store_tap        = 1'b1;
        end
      end else if (page_turn_mode == MODE_SWIPE && !poll_q.tap_right) begin
        tap_handled = 1'b1;
        tap_kind    = KIND_CONTENTS;
      end else if (page_turn_mode == MODE_TAP) begin
        tap_handled = 1'b1;
        tap_kind    = poll_q.tap_right ? KIND_NEXT : KIND_PREV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_pending <= 1'b0;
    end else if (advance) begin
      tap_pending <= tap_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && store_tap) begin
      pending_forward <= poll_q.tap_right;
      pending_time    <= now;
    end
  end

  // Buttons: up is examined when the tap logic handled nothing, down only
  // when up consumed nothing as well.
  btn_cfg_t   up_cfg;
  btn_cfg_t   down_cfg;
  logic       up_step;
  logic       down_step;
  logic       up_fire;
  logic       down_fire;
  logic [7:0] up_code;
  logic [7:0] down_code;

  assign up_cfg    = '{long_ms: long_press_ms, short_code: up_short_action,
                       long_code: up_long_action};
  assign down_cfg  = '{long_ms: long_press_ms, short_code: down_short_action,
                       long_code: down_long_action};
  assign up_step   = advance && !tap_handled;
  assign down_step = up_step && !up_fire;

  ptgc_button #(.TIME_BITS(TIME_BITS)) u_up (
    .clk     (clk),
    .rst     (rst),
    .step    (up_step),
    .pressed (poll_q.up_pressed),
    .now     (now),
    .cfg     (up_cfg),
    .fire    (up_fire),
    .code    (up_code)
  );

  ptgc_button #(.TIME_BITS(TIME_BITS)) u_down (
    .clk     (clk),
    .rst     (rst),
    .step    (down_step),
    .pressed (poll_q.down_pressed),
    .now     (now),
    .cfg     (down_cfg),
    .fire    (down_fire),
    .code    (down_code)
  );

  // Result selection in priority order: tap logic, up button, down button.
  gesture_t gesture_next;

  always_comb begin
    gesture_next = '{handled: 1'b0, gesture_kind: KIND_NONE, action_code: 8'd0};
    if (tap_handled) begin
      gesture_next = '{handled: 1'b1, gesture_kind: tap_kind, action_code: tap_code};
    end else if (up_fire) begin
      gesture_next = '{handled: 1'b1, gesture_kind: KIND_ACTION, action_code: up_code};
    end else if (down_fire) begin
      gesture_next = '{handled: 1'b1, gesture_kind: KIND_ACTION,
                       action_code: down_code};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      gesture_valid <= 1'b0;
    end else if (advance) begin
      gesture_valid <= 1'b1;
    end else if (gesture_ready) begin
      gesture_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gesture <= gesture_next;
    end
  end

  // Every poll that leaves the input register shows up as a result.
  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> gesture_valid)
    else $error("advanced poll produced no result");

  // The action code is only carried by configured actions.
  a_code_only_for_action: assert property (@(posedge clk) disable iff (rst)
    gesture_valid && gesture.gesture_kind != KIND_ACTION |-> gesture.action_code == 8'd0)
    else $error("action code set on a non-action gesture");

  // A named gesture always consumes its event.
  a_kind_implies_handled: assert property (@(posedge clk) disable iff (rst)
    gesture_valid && gesture.gesture_kind != KIND_NONE |-> gesture.handled)
    else $error("gesture reported as unhandled");

  // A tap with double tap enabled either becomes pending or completes a pair.
  a_double_tap_outcome: assert property (@(posedge clk) disable iff (rst)
    advance && !(expired && page_turn_mode == MODE_TAP) && poll_q.tap_event &&
    double_tap_action != 8'd0
    |=> tap_pending || gesture.gesture_kind == KIND_ACTION)
    else $error("double-tap enabled tap neither pending nor fired");

  // The down button never fires in a poll where the up button fired.
  a_single_button: assert property (@(posedge clk) disable iff (rst)
    up_step && up_fire |-> !down_step)
    else $error("both buttons stepped in one firing poll");

endmodule
